// ===== hw/rtl/rfc_pkg.sv =====
// Shared types, constants and the CRC-24Q byte update for the RTCM3 frame checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rfc_pkg;

    localparam logic [7:0]  PREAMBLE       = 8'hD3;
    localparam logic [1:0]  LEN_HI_MASK    = 2'b11;
    localparam logic [23:0] CRC_POLY       = 24'h864CFB;
    localparam int          LEN_W          = 11;
    localparam logic [10:0] LEN_OVERHEAD   = 11'd6;
    localparam logic [10:0] LIMIT_RESET    = 11'd1029;
    localparam int          QUEUE_DEPTH_DEF = 2;

    // Frame verdicts carried on the last byte.
    localparam logic [1:0]  ST_GOOD     = 2'd0;
    localparam logic [1:0]  ST_CRC_ERR  = 2'd1;
    localparam logic [1:0]  ST_TOO_LONG = 2'd2;

    // How the back end treats a byte.
    typedef enum logic [1:0] {
        K_FIRST   = 2'd0,   // preamble: restart CRC and trailer capture
        K_CRC     = 2'd1,   // header or payload: fold into CRC
        K_TRAILER = 2'd2,   // trailing CRC byte: shift into received CRC
        K_ABANDON = 2'd3    // length byte of a frame over the limit
    } t_kind;

    typedef struct packed {
        logic [7:0]       data;
        logic [LEN_W-1:0] offset;
        logic             last;
        t_kind            kind;
    } t_item;

    // One byte of CRC-24Q, MSB first, eight bit steps unrolled.
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_in,
                                                input logic [7:0]  b);
        logic [23:0] c;
        c = crc_in ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            if (c[23]) begin
                c = {c[22:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[22:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rfc_front.sv =====
// Front end: preamble hunt, length decode, limit check and byte classification.
// Depends on rfc_pkg; feeds the request queue.
`default_nettype none

module rfc_front
    import rfc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_wdata,
    input  wire logic             i_valid,
    output      logic             o_ready,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_q_full,
    output      logic             o_push,
    output      t_item            o_item
);

    typedef enum logic [3:0] {
        S_HUNT   = 4'b0001,
        S_LEN_HI = 4'b0010,
        S_LEN_LO = 4'b0100,
        S_BODY   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_total, n_total;
    logic [1:0]       r_len_hi, n_len_hi;
    logic [LEN_W-1:0] r_limit;

    logic             accept;
    logic [LEN_W-1:0] total;
    logic [LEN_W:0]   count_p3;
    logic [LEN_W:0]   count_p1;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign total    = {1'b0, r_len_hi, i_byte} + LEN_OVERHEAD;
    assign count_p3 = {1'b0, r_count} + (LEN_W + 1)'(3);
    assign count_p1 = {1'b0, r_count} + (LEN_W + 1)'(1);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_total       = r_total;
        n_len_hi      = r_len_hi;
        o_push        = 1'b0;
        o_item.data   = i_byte;
        o_item.offset = r_count;
        o_item.last   = 1'b0;
        o_item.kind   = K_CRC;
        if (accept) begin
            unique case (r_state)
                S_HUNT: begin
                    if (i_byte == PREAMBLE) begin
                        o_push      = 1'b1;
                        o_item.kind = K_FIRST;
                        n_count     = LEN_W'(1);
                        n_state     = S_LEN_HI;
                    end
                end
                S_LEN_HI: begin
                    o_push   = 1'b1;
                    n_len_hi = i_byte[1:0] & LEN_HI_MASK;
                    n_count  = LEN_W'(2);
                    n_state  = S_LEN_LO;
                end
                S_LEN_LO: begin
                    o_push = 1'b1;
                    if (total > r_limit) begin
                        o_item.last = 1'b1;
                        o_item.kind = K_ABANDON;
                        n_count     = '0;
                        n_len_hi    = '0;
                        n_state     = S_HUNT;
                    end else begin
                        n_total = total;
                        n_count = LEN_W'(3);
                        n_state = S_BODY;
                    end
                end
                S_BODY: begin
                    o_push      = 1'b1;
                    o_item.kind = (count_p3 < {1'b0, r_total}) ? K_CRC : K_TRAILER;
                    if (count_p1 >= {1'b0, r_total}) begin
                        o_item.last = 1'b1;
                        n_count     = '0;
                        n_len_hi    = '0;
                        n_total     = '0;
                        n_state     = S_HUNT;
                    end else begin
                        n_count = count_p1[LEN_W-1:0];
                    end
                end
                default: begin
                    n_state = S_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_HUNT;
            r_count  <= '0;
            r_total  <= '0;
            r_len_hi <= '0;
            r_limit  <= LIMIT_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_total  <= n_total;
            r_len_hi <= n_len_hi;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_queue.sv =====
// Short request queue between the front and back ends of the frame checker.
// Depends on rfc_pkg for the request type; depth defaults to QUEUE_DEPTH_DEF.
`default_nettype none

module rfc_queue
    import rfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output      logic  o_full,
    input  wire logic  i_pop,
    output      logic  o_valid,
    output      t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_back.sv =====
// Back end: CRC-24Q accumulation, trailer capture, verdict and output register.
// Depends on rfc_pkg; drains the request queue.
`default_nettype none

module rfc_back
    import rfc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_item            i_item,
    output      logic             o_pop,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      logic [7:0]       o_data,
    output      logic [LEN_W-1:0] o_offset,
    output      logic             o_last,
    output      logic [1:0]       o_status
);

    logic [23:0]      r_crc, n_crc;
    logic [23:0]      r_rx_crc, n_rx_crc;
    logic             r_valid;
    logic [7:0]       r_data;
    logic [LEN_W-1:0] r_offset;
    logic             r_last;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic [23:0]      crc_step;

    // Advance whenever the output register is empty or being taken.
    assign o_pop    = i_q_valid && (!r_valid || i_ready);
    assign crc_step = crc24q_byte((i_item.kind == K_FIRST) ? 24'h0 : r_crc, i_item.data);

    always_comb begin
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;
        n_status = ST_GOOD;
        unique case (i_item.kind)
            K_FIRST: begin
                n_crc    = crc_step;
                n_rx_crc = '0;
            end
            K_CRC: begin
                n_crc = crc_step;
            end
            K_TRAILER: begin
                n_rx_crc = {r_rx_crc[15:0], i_item.data};
                if (i_item.last) begin
                    n_status = (n_rx_crc == r_crc) ? ST_GOOD : ST_CRC_ERR;
                end
            end
            K_ABANDON: begin
                n_status = ST_TOO_LONG;
            end
            default: begin
                n_status = ST_GOOD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= i_item.data;
            r_offset <= i_item.offset;
            r_last   <= i_item.last;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_crc    <= '0;
            r_rx_crc <= '0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_crc    <= n_crc;
                r_rx_crc <= n_rx_crc;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_offset = r_offset;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule

`default_nettype wire

// ===== hw/rtl/rtcm3_frame_checker_unit.sv =====
// RTCM3 frame checker: preamble hunt, length check and CRC-24Q verification.
// An accepted byte is written into the request queue and then into the back end's output
// register, from which the master side takes it.
// Throughput: one byte per cycle unless the master side stalls; the CRC byte update is combinational.
// Reset (synchronous, active low): hunting for the preamble, queue and output empty,
// limit back to 1029. Depends on rfc_pkg, rfc_front, rfc_queue and rfc_back.
`default_nettype none

module rtcm3_frame_checker_unit
    import rfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Configuration: frame_length_limit.
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_wdata,
    // Slave side: one received byte per request.
    input  wire logic             s_axis_tvalid,
    output      logic             s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    // Master side: one frame byte per request.
    output      logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output      logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [18:8] byte_offset, zeros
    output      logic             m_axis_tlast,   // last
    output      logic [1:0]       m_axis_tuser    // [1:0] frame_status
);

    logic             q_full;
    logic             q_valid;
    logic             push;
    logic             pop;
    t_item            push_item;
    t_item            pop_item;
    logic [7:0]       out_data;
    logic [LEN_W-1:0] out_offset;

    // Front end: hunt, decode the length, drop bytes outside a frame and tag the rest.
    rfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    // Hold tagged requests so that a stalled master side does not stall the hunt at once.
    rfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    // Back end: run the CRC, capture the trailer and attach the verdict.
    rfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (pop_item),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (out_data),
        .o_offset  (out_offset),
        .o_last    (m_axis_tlast),
        .o_status  (m_axis_tuser)
    );

    assign m_axis_tdata = {5'b00000, out_offset, out_data};

endmodule

`default_nettype wire

// ===== tb/tb_rtcm3_frame_checker_unit.sv =====
// Self-checking testbench for rtcm3_frame_checker_unit: byte stream in, checked frame bytes out.
// Predicts every output byte, offset and verdict from its own framing and CRC-24Q tracker.
// Depends on rfc_pkg and the rtcm3_frame_checker_unit top level.

module tb_rtcm3_frame_checker_unit;

    import rfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned DRAIN_CYCLES = 8;      // lets the queue and output register empty, with margin
    localparam int unsigned NUM_PHASES   = 9;
    localparam int unsigned PHASE_BYTES  = 80;

    typedef enum {FAULT_NONE, FAULT_CRC, FAULT_CUT} t_frame_fault;

    // One byte of a frame as it should leave the block.
    typedef struct packed {
        logic [7:0]       data;
        logic [LEN_W-1:0] offset;
        logic             last;
        logic [1:0]       status;
    } t_frame_byte;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;   // [7:0] rx_byte
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;         // [7:0] data_byte, [18:8] byte_offset, zeros
    logic             m_axis_tlast;         // last
    logic [1:0]       m_axis_tuser;         // [1:0] frame_status

    rtcm3_frame_checker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Bytes waiting to be sent, and frame bytes the block still owes us.
    logic [7:0]  rx_pending[$];
    t_frame_byte pending_frame_bytes[$];

    // Tracker state: mirrors the block's framing and CRC registers.
    logic [LEN_W-1:0] limit_copy = LIMIT_RESET;
    logic [LEN_W-1:0] hunt_pos   = '0;
    logic [LEN_W-1:0] frame_len  = '0;
    logic [1:0]       len_hi     = '0;
    logic [23:0]      crc_run    = '0;
    logic [23:0]      crc_rx     = '0;

    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;
    int unsigned bytes_in     = 0;
    int unsigned bytes_out    = 0;
    int unsigned frames_good  = 0;
    int unsigned frames_crc   = 0;
    int unsigned frames_long  = 0;
    int unsigned send_gap     = 0;
    int unsigned rcv_hold     = 0;
    bit          in_taken     = 1'b0;
    bit          steady_run   = 1'b0;

    // CRC-24Q over one byte, MSB first, done with a 25-bit register and the full polynomial.
    function automatic logic [23:0] crc24q_next(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] r;
        r = {1'b0, crc ^ {b, 16'h0000}};
        repeat (8) begin
            r = r << 1;
            if (r[24]) begin
                r = r ^ 25'h1864CFB;
            end
        end
        return r[23:0];
    endfunction

    function automatic void restart_hunt();
        hunt_pos  = '0;
        frame_len = '0;
        len_hi    = '0;
        crc_run   = '0;
        crc_rx    = '0;
    endfunction

    // Advance the tracker by one received byte; return 1 when the byte belongs to a frame.
    function automatic bit track_byte(input logic [7:0] b, output t_frame_byte fb);
        logic [LEN_W-1:0] total;
        fb.data   = b;
        fb.offset = hunt_pos;
        fb.last   = 1'b0;
        fb.status = ST_GOOD;
        if (hunt_pos == 0) begin
            if (b != PREAMBLE) begin
                return 1'b0;
            end
            crc_run   = crc24q_next('0, b);
            crc_rx    = '0;
            frame_len = '0;
            hunt_pos  = LEN_W'(1);
        end else if (hunt_pos == 1) begin
            len_hi   = b[1:0] & LEN_HI_MASK;
            crc_run  = crc24q_next(crc_run, b);
            hunt_pos = LEN_W'(2);
        end else if (hunt_pos == 2) begin
            total   = {1'b0, len_hi, b} + LEN_OVERHEAD;
            crc_run = crc24q_next(crc_run, b);
            if (total > limit_copy) begin
                // Too long: verdict on the length byte, then back to hunting.
                fb.last   = 1'b1;
                fb.status = ST_TOO_LONG;
                restart_hunt();
            end else begin
                frame_len = total;
                hunt_pos  = LEN_W'(3);
            end
        end else begin
            // Payload folds into the CRC, the final three bytes form the received CRC.
            if ({1'b0, hunt_pos} + 12'd3 < {1'b0, frame_len}) begin
                crc_run = crc24q_next(crc_run, b);
            end else begin
                crc_rx = {crc_rx[15:0], b};
            end
            if ({1'b0, hunt_pos} + 12'd1 >= {1'b0, frame_len}) begin
                fb.last   = 1'b1;
                fb.status = (crc_rx == crc_run) ? ST_GOOD : ST_CRC_ERR;
                restart_hunt();
            end else begin
                hunt_pos = hunt_pos + 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, none at all during a steady run.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Line noise between frames; keep the preamble out so frames stay aligned.
    function automatic logic [7:0] stray_byte();
        logic [7:0] v;
        do begin
            v = 8'($urandom);
        end while (v == PREAMBLE);
        return v;
    endfunction

    // Build a frame with a correct trailer, then damage it as asked, or cut it after the length byte if over the limit.
    task automatic queue_frame(input logic [7:0] body[$], input logic [5:0] spare,
                               input t_frame_fault fault, output int unsigned n);
        logic [7:0]  fb[$];
        logic [23:0] crc;
        logic [9:0]  plen;
        int unsigned at;
        plen = 10'(body.size());
        fb   = '{PREAMBLE, {spare, plen[9:8]}, plen[7:0]};
        fb   = {fb, body};
        crc  = '0;
        foreach (fb[i]) begin
            crc = crc24q_next(crc, fb[i]);
        end
        fb.push_back(crc[23:16]);
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        if ({1'b0, plen} + LEN_OVERHEAD > limit_copy) begin
            // Abandoned on the length byte: follow with stray bytes, not the whole body.
            fb = fb[0:2];
            repeat ($urandom_range(0, 12)) begin
                fb.push_back(stray_byte());
            end
        end else if (fault == FAULT_CRC) begin
            at     = $urandom_range(3, fb.size() - 1);
            fb[at] = fb[at] ^ (8'h01 << $urandom_range(0, 7));
        end else if (fault == FAULT_CUT) begin
            // Broken frame: the next frame's bytes get swallowed as its tail.
            fb = fb[0:$urandom_range(3, fb.size() - 2)];
        end
        foreach (fb[i]) begin
            rx_pending.push_back(fb[i]);
        end
        n = fb.size();
    endtask

    // Payload length for the next random frame, shaped around the current limit.
    function automatic int unsigned pick_payload_len();
        int unsigned r;
        int unsigned lo;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return $urandom_range(0, 12);
        end
        if (r < 85) begin
            return $urandom_range(13, 80);
        end
        if (r < 93) begin
            // Right on the limit, or one byte past it.
            if (limit_copy >= 6 && limit_copy <= 300) begin
                return limit_copy - 6 + $urandom_range(0, 1);
            end
            return $urandom_range(0, 30);
        end
        if (limit_copy <= 1028) begin
            lo = (limit_copy < 6) ? 0 : limit_copy - 5;
            return $urandom_range(lo, 1023);
        end
        return $urandom_range(81, 200);
    endfunction

    // Hold until nothing is queued, in flight or owed, then let the pipeline settle.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (rx_pending.size() != 0 || s_axis_tvalid || pending_frame_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_limit(input logic [LEN_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_copy = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender: present the next byte once the previous request has gone through.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
                s_axis_tdata  <= rx_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = idle_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random; now and then switch into or out of a steady run.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            steady_run = !steady_run;
        end
        if (rcv_hold == 0 && $urandom_range(0, 7) == 0) begin
            rcv_hold = idle_gap();
        end
        if (rcv_hold > 0) begin
            rcv_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted byte, check each delivered frame byte.
    always @(posedge i_clk) begin
        t_frame_byte exp_fb;
        t_frame_byte got_fb;
        in_taken = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            in_taken = 1'b1;
            bytes_in++;
            if (track_byte(s_axis_tdata, exp_fb)) begin
                pending_frame_bytes.push_back(exp_fb);
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_fb.data   = m_axis_tdata[7:0];
            got_fb.offset = m_axis_tdata[18:8];
            got_fb.last   = m_axis_tlast;
            got_fb.status = m_axis_tuser;
            bytes_out++;
            if (pending_frame_bytes.size() == 0) begin
                $error("unexpected frame byte %02h at offset %0d", got_fb.data, got_fb.offset);
                mismatches++;
            end else begin
                exp_fb = pending_frame_bytes.pop_front();
                if (got_fb.data !== exp_fb.data) begin
                    $error("data_byte: expected %02h, got %02h", exp_fb.data, got_fb.data);
                    mismatches++;
                end
                if (got_fb.offset !== exp_fb.offset) begin
                    $error("byte_offset: expected %0d, got %0d", exp_fb.offset, got_fb.offset);
                    mismatches++;
                end
                if (got_fb.last !== exp_fb.last) begin
                    $error("last: expected %0b, got %0b", exp_fb.last, got_fb.last);
                    mismatches++;
                end
                if (got_fb.status !== exp_fb.status) begin
                    $error("frame_status: expected %0d, got %0d", exp_fb.status, got_fb.status);
                    mismatches++;
                end
                if (exp_fb.last) begin
                    case (exp_fb.status)
                        ST_GOOD:    frames_good++;
                        ST_CRC_ERR: frames_crc++;
                        default:    frames_long++;
                    endcase
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frame bytes still owed",
                     cycle_count, pending_frame_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [7:0]       body[$];
        logic [LEN_W-1:0] phase_limits[NUM_PHASES];
        int unsigned      built;
        int unsigned      n;
        int unsigned      r;
        t_frame_fault     fault;

        // Reset limit first, then the extremes of the register, then mid and random values.
        phase_limits = '{LIMIT_RESET, 11'd2047, 11'd6, 11'd0, 11'd47, 11'd1028,
                         11'($urandom_range(6, 300)), 11'd300, LIMIT_RESET};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                apply_limit(phase_limits[p]);
            end
            if (p == 0) begin
                // Noise at both byte extremes, then short frames: empty and clean,
                // preamble as payload, and a CRC error.
                rx_pending.push_back(8'h00);
                rx_pending.push_back(8'hFF);
                rx_pending.push_back(8'h5A);
                body = {};
                queue_frame(body, 6'h3F, FAULT_NONE, n);
                body = '{PREAMBLE};
                queue_frame(body, 6'h00, FAULT_NONE, n);
                body = '{PREAMBLE, 8'h00};
                queue_frame(body, 6'h15, FAULT_CRC, n);
                // Largest frame, exactly at the reset limit: offsets reach their top.
                body = {};
                repeat (1023) body.push_back(8'($urandom));
                queue_frame(body, 6'($urandom), FAULT_NONE, n);
            end
            built = 0;
            while (built < PHASE_BYTES) begin
                body = {};
                repeat (pick_payload_len()) body.push_back(8'($urandom));
                r     = $urandom_range(0, 99);
                fault = (r < 80) ? FAULT_NONE : (r < 94) ? FAULT_CRC : FAULT_CUT;
                queue_frame(body, 6'($urandom), fault, n);
                built += n;
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        rx_pending.push_back(stray_byte());
                        built++;
                    end
                end
            end
            // Sender pauses here until every owed byte has come back.
            wait_drained();
        end

        $display("Sent %0d bytes under %0d limit settings; checked %0d frame bytes.",
                 bytes_in, NUM_PHASES, bytes_out);
        $display("Verdicts seen: %0d good, %0d CRC errors, %0d too long.",
                 frames_good, frames_crc, frames_long);
        if (mismatches == 0 && pending_frame_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
